// File: design/omse_pkg.sv
// Shared constants, types and helper functions for the online max / exp-sum unit.
package omse_pkg;

  localparam int SUM_WIDTH = 32;
  localparam int SAMPLE_W = 16;
  localparam int OUT_SUM_W = 32;
  localparam int EXP_W = 17;
  localparam int MUL_AW = (SUM_WIDTH - 16 > 16) ? SUM_WIDTH - 16 : 16;
  localparam int MUL_BW = 17;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int SUMX_W = (SUM_WIDTH > OUT_SUM_W) ? SUM_WIDTH : OUT_SUM_W;

  localparam logic [EXP_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [MUL_BW-1:0] LOG2E_Q16 = 17'd94548;
  localparam logic [8:0] EXP_SHIFT_MAX = 9'd16;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXPT = 6'b000010,
    S_EXPV = 6'b000100,
    S_SCLO = 6'b001000,
    S_SCHI = 6'b010000,
    S_DONE = 6'b100000
  } omse_state_t;

  function automatic logic [EXP_W-1:0] pow2_tab(input logic [4:0] idx);
    logic [EXP_W-1:0] v;
    case (idx)
      5'd0: v = 17'd65536;
      5'd1: v = 17'd62757;
      5'd2: v = 17'd60097;
      5'd3: v = 17'd57549;
      5'd4: v = 17'd55109;
      5'd5: v = 17'd52773;
      5'd6: v = 17'd50535;
      5'd7: v = 17'd48393;
      5'd8: v = 17'd46341;
      5'd9: v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      5'd16: v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

  function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] a,
                                                   input logic [SUM_WIDTH-1:0] b);
    logic [SUM_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : s[SUM_WIDTH-1:0];
  endfunction

  function automatic logic [OUT_SUM_W-1:0] sum_to_out(input logic [SUM_WIDTH-1:0] s);
    logic [SUMX_W-1:0] ext;
    ext = SUMX_W'(s);
    return (ext > SUMX_W'({OUT_SUM_W{1'b1}})) ? {OUT_SUM_W{1'b1}} : ext[OUT_SUM_W-1:0];
  endfunction

endpackage

// File: design/online_max_sum_exp_unit.sv
// Online softmax normalizer: running row maximum and saturating sum of exp(x - max).
//
// Usage: samples (signed Q8.8) enter on in_sample with in_last marking the final
// sample of a row. One result per row leaves on out_row_max (signed Q8.8) and
// out_exp_sum (unsigned Q16.16, saturated to 32 bits).
// Both channels use valid/ready; a request moves when valid and ready are high.
// Samples are taken one at a time: in_ready is high only in the idle step, so a
// new sample waits until the previous one is through. The first sample of a row
// goes straight to the final step; a sample not above the running maximum passes
// through the exponential steps; a new maximum also takes the sum rescale steps.
// The shared multiplier serves the exponential and the sum rescale in turn.
// The result sits in an output register; the unit takes further samples while
// it waits. If a row finishes while the previous result is still stalled, the
// unit holds in its final step until the receiver takes that result.
// Reset (rst_n low, synchronous) clears the running state and closes the row,
// so the next sample starts a new row; no result is pending after reset.
module online_max_sum_exp_unit
  import omse_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  out_row_max,
  output logic [OUT_SUM_W-1:0]        out_exp_sum
);

  omse_state_t state_r, state_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;
  logic [SUM_WIDTH-1:0] sum_r, sum_nxt;
  logic row_open_r, row_open_nxt;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic last_r, last_nxt;
  logic [SAMPLE_W-1:0] mag_r, mag_nxt;
  logic ge_r, ge_nxt;
  logic [8:0] tn_r, tn_nxt;
  logic [3:0] ti_r, ti_nxt;
  logic [11:0] tr_r, tr_nxt;
  logic [EXP_W-1:0] e_r, e_nxt;
  logic [EXP_W-1:0] acc_r, acc_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_max_r, out_max_nxt;
  logic [OUT_SUM_W-1:0] out_sum_r, out_sum_nxt;

  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_p;
  logic [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0] diff_abs;
  logic [EXP_W-1:0] tab_hi;
  logic [EXP_W-1:0] tab_lo;
  logic [11:0] tab_step;
  logic [EXP_W-1:0] interp;
  logic [EXP_W-1:0] e_val;
  logic [SUM_WIDTH-1:0] scaled;

  assign diff = {max_r[SAMPLE_W-1], max_r} - {in_sample[SAMPLE_W-1], in_sample};
  assign diff_abs = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;

  assign tab_hi = pow2_tab({1'b0, ti_r});
  assign tab_lo = pow2_tab(5'({1'b0, ti_r}) + 5'd1);
  assign tab_step = 12'(tab_hi - tab_lo);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_EXPT: begin
        mul_a = MUL_AW'(mag_r);
        mul_b = LOG2E_Q16;
      end
      S_EXPV: begin
        mul_a = MUL_AW'(tab_step);
        mul_b = MUL_BW'(tr_r);
      end
      S_SCLO: begin
        mul_a = MUL_AW'(sum_r[15:0]);
        mul_b = e_r;
      end
      S_SCHI: begin
        mul_a = MUL_AW'(sum_r[SUM_WIDTH-1:16]);
        mul_b = e_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MUL_PW'(mul_a) * MUL_PW'(mul_b);

  assign interp = tab_hi - EXP_W'(mul_p[23:12]);
  assign e_val = (tn_r > EXP_SHIFT_MAX) ? '0 : (interp >> tn_r[4:0]);
  assign scaled = mul_p[SUM_WIDTH-1:0] + SUM_WIDTH'(acc_r);

  always_comb begin
    state_nxt = state_r;
    max_nxt = max_r;
    sum_nxt = sum_r;
    row_open_nxt = row_open_r;
    x_nxt = x_r;
    last_nxt = last_r;
    mag_nxt = mag_r;
    ge_nxt = ge_r;
    tn_nxt = tn_r;
    ti_nxt = ti_r;
    tr_nxt = tr_r;
    e_nxt = e_r;
    acc_nxt = acc_r;
    out_max_nxt = out_max_r;
    out_sum_nxt = out_sum_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt = in_sample;
          last_nxt = in_last;
          if (!row_open_r) begin
            max_nxt = in_sample;
            sum_nxt = SUM_WIDTH'(ONE_Q16);
            state_nxt = S_DONE;
          end else begin
            mag_nxt = diff_abs[SAMPLE_W-1:0];
            ge_nxt = !diff[SAMPLE_W];
            state_nxt = S_EXPT;
          end
        end
      end
      S_EXPT: begin
        tn_nxt = mul_p[32:24];
        ti_nxt = mul_p[23:20];
        tr_nxt = mul_p[19:8];
        state_nxt = S_EXPV;
      end
      S_EXPV: begin
        e_nxt = e_val;
        if (ge_r) begin
          sum_nxt = sat_add(sum_r, SUM_WIDTH'(e_val));
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCLO;
        end
      end
      S_SCLO: begin
        acc_nxt = mul_p[32:16];
        state_nxt = S_SCHI;
      end
      S_SCHI: begin
        sum_nxt = sat_add(scaled, SUM_WIDTH'(ONE_Q16));
        max_nxt = x_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (last_r) begin
          // hold until the previous result is taken
          if (!out_valid_r || out_ready) begin
            out_max_nxt = max_r;
            out_sum_nxt = sum_to_out(sum_r);
            out_valid_nxt = 1'b1;
            row_open_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
        end else begin
          row_open_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      max_r <= '0;
      sum_r <= '0;
      row_open_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      max_r <= max_nxt;
      sum_r <= sum_nxt;
      row_open_r <= row_open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    last_r <= last_nxt;
    mag_r <= mag_nxt;
    ge_r <= ge_nxt;
    tn_r <= tn_nxt;
    ti_r <= ti_nxt;
    tr_r <= tr_nxt;
    e_r <= e_nxt;
    acc_r <= acc_nxt;
    out_max_r <= out_max_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_row_max = out_max_r;
  assign out_exp_sum = out_sum_r;

  a_sum_floor: assert property (@(posedge clk) disable iff (!rst_n)
    row_open_r |-> (sum_r >= SUM_WIDTH'(ONE_Q16)))
    else $error("running sum fell below one while a row is open");

  a_first_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !row_open_r) |=> (state_r == S_DONE))
    else $error("first sample of a row did not go straight to the final step");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE && last_r))
    else $error("result raised outside the final step of a row");

  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCLO || state_r == S_SCHI) |-> (e_r <= ONE_Q16))
    else $error("exponential exceeds one");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

endmodule

// File: dv/tb_online_max_sum_exp_unit.sv
// Testbench for the online max / exp-sum unit: directed and random rows checked against a predictor.
module tb_online_max_sum_exp_unit;
  import omse_pkg::*;

  typedef struct {
    logic signed [SAMPLE_W-1:0] row_max;
    logic [OUT_SUM_W-1:0]       exp_sum;
  } row_result_t;

  class row_norm_scoreboard;
    logic signed [SAMPLE_W-1:0] cur_max;
    longint unsigned            cur_sum;
    bit                         row_open;
    longint unsigned            sum_cap;
    int unsigned                pow2_steps[17];
    row_result_t                rows_due[$];
    int                         mismatches;

    function new();
      cur_max = '0;
      cur_sum = 0;
      row_open = 1'b0;
      mismatches = 0;
      sum_cap = (64'd1 << SUM_WIDTH) - 64'd1;
      pow2_steps = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                     46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
    endfunction

    function longint unsigned clip_add(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > sum_cap) ? sum_cap : s;
    endfunction

    // exp(-mag / 256) in Q16.16
    function longint unsigned exp_neg_q16(int unsigned mag);
      longint unsigned t;
      longint unsigned n;
      int unsigned     f;
      int unsigned     idx;
      int unsigned     frac;
      int unsigned     v;
      t = (64'(mag) * 64'(LOG2E_Q16)) >> 8;
      n = t >> 16;
      f = 32'(t & 64'hFFFF);
      idx = f >> 12;
      frac = f & 32'hFFF;
      if (n > 16) return 0;
      v = pow2_steps[idx] - (((pow2_steps[idx] - pow2_steps[idx + 1]) * frac) >> 12);
      return 64'(v >> n);
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] x, logic last);
      int              diff;
      longint unsigned e;
      row_result_t     res;
      diff = int'(x) - int'(cur_max);
      if (!row_open) begin
        cur_max = x;
        cur_sum = clip_add(0, 64'(ONE_Q16));
      end else if (diff <= 0) begin
        cur_sum = clip_add(cur_sum, exp_neg_q16(-diff));
      end else begin
        e = exp_neg_q16(diff);
        cur_sum = clip_add((cur_sum >> 16) * e + (((cur_sum & 64'hFFFF) * e) >> 16),
                           64'(ONE_Q16));
        cur_max = x;
      end
      if (last) begin
        res.row_max = cur_max;
        res.exp_sum = (cur_sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : OUT_SUM_W'(cur_sum);
        rows_due.push_back(res);
        row_open = 1'b0;
      end else begin
        row_open = 1'b1;
      end
    endfunction

    function void check_row(logic signed [SAMPLE_W-1:0] mx, logic [OUT_SUM_W-1:0] s);
      row_result_t want;
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected result row_max=%0d exp_sum=%h", $time, mx, s);
        mismatches++;
        return;
      end
      want = rows_due.pop_front();
      if (want.row_max !== mx) begin
        $display("%0t: row_max expected %0d actual %0d", $time, want.row_max, mx);
        mismatches++;
      end
      if (want.exp_sum !== s) begin
        $display("%0t: exp_sum expected %h actual %h", $time, want.exp_sum, s);
        mismatches++;
      end
    endfunction

    function int pending();
      return rows_due.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       in_last = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_row_max;
  logic [OUT_SUM_W-1:0]       out_exp_sum;

  row_norm_scoreboard sb;
  bit                 no_gaps = 1'b0;
  int                 samples_sent = 0;

  online_max_sum_exp_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_row_max (out_row_max),
    .out_exp_sum (out_exp_sum)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= no_gaps || ($urandom_range(99) >= 27);
    if (rst_n && out_valid && out_ready) sb.check_row(out_row_max, out_exp_sum);
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic last);
    while (!no_gaps && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= x;
    in_last <= last;
    do @(posedge clk); while (!in_ready);
    sb.take_sample(x, last);
    samples_sent++;
  endtask

  task automatic wait_for_rows();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_row();
    int len;
    int spread;
    int base;
    int v;
    bit wide;
    wide = ($urandom_range(99) < 25);
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
    case ($urandom_range(2))
      0: spread = 16;
      1: spread = 256;
      default: spread = 2048;
    endcase
    base = int'($urandom_range(65535 - 2 * spread, 0)) - 32768 + spread;
    for (int k = 0; k < len; k++) begin
      if (wide) v = int'($urandom_range(65535, 0)) - 32768;
      else v = base + int'($urandom_range(2 * spread, 0)) - spread;
      send_sample(SAMPLE_W'(v), k == len - 1);
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh0100, 1'b0);
    send_sample(16'sh0100, 1'b0);
    send_sample(16'sh0100, 1'b1);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0100, 1'b0);
    send_sample(16'sh0080, 1'b0);
    send_sample(-16'sd4096, 1'b0);
    send_sample(16'sh012C, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shAAAA, 1'b1);

    // hold the sender until every row result is back
    wait_for_rows();

    samples_sent = 0;
    while (samples_sent < 500) begin
      no_gaps = (samples_sent >= 180 && samples_sent < 300);
      send_random_row();
    end
    no_gaps = 1'b0;
    wait_for_rows();

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[online_max_sum_exp_unit] OK");
    end else begin
      $display("[online_max_sum_exp_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #48_000_000;
    $display("[online_max_sum_exp_unit] ERROR");
    $finish;
  end

endmodule

// File: online_max_sum_exp_unit.f
design/omse_pkg.sv
design/online_max_sum_exp_unit.sv
dv/tb_online_max_sum_exp_unit.sv
